[rtl/skewed_triangle_oscillator_top_defines.svh]
// ----------------------------------------------------------------------------
// Skewed triangle oscillator assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SKEWED_TRIANGLE_OSCILLATOR_TOP_DEFINES_SVH
`define SKEWED_TRIANGLE_OSCILLATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define STO_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define STO_ASSERT(lbl, prop) `STO_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define STO_ASSERT_CLK(lbl, clk, rst_n, prop)
`define STO_ASSERT(lbl, prop)
`endif

`endif

[rtl/sto_pkg.sv]
// ----------------------------------------------------------------------------
// Skewed triangle oscillator package
// Register map and fixed widths shared by the oscillator modules.
// ----------------------------------------------------------------------------
package sto_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RISE_INC     = 3'd0,
    REG_FALL_INC     = 3'd1,
    REG_OUT_MAX      = 3'd2,
    REG_OUT_MIN      = 3'd3,
    REG_START_PHASE  = 3'd4,
    REG_START_RISING = 3'd5
  } reg_idx_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

[rtl/skewed_triangle_oscillator_top.sv]
// ----------------------------------------------------------------------------
// Skewed triangle oscillator
// Asymmetric triangle wave generator with APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat (in_valid_i/in_ready_o, field restart_i) is one tick and
//   yields exactly one output beat (out_valid_o/out_ready_i, field sample_o).
//   restart_i reloads phase and direction from start_phase/start_rising
//   before the tick's step.
//   Throughput: one beat per cycle while the pipe is not stalled. Three register
//   stages (phase, product, sample); out_valid_o is the valid bit of the last.
//   The phase add-and-clamp is the only loop; it is combinational into phase_q.
//   Stall: the whole pipe holds while out_valid_o is high and out_ready_i is
//   low; in_ready_o drops in that case and rises as soon as the output
//   register drains or is taken.
//   Reset: pipe empty, phase 0, rising; registers zero, start_rising 1.
//   Registers sit at 4*index (8*index when the phase exceeds 32 bits):
//   rise_inc, fall_inc, out_max, out_min, start_phase, start_rising.
//   Write only while the pipe is empty.
// ----------------------------------------------------------------------------
`include "skewed_triangle_oscillator_top_defines.svh"

module skewed_triangle_oscillator_top #(
  parameter int unsigned PHASE_FRAC_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                                            psel,
  input  logic                                            penable,
  input  logic                                            pwrite,
  input  logic [((PHASE_FRAC_BITS >= 32) ? 3 : 2)+2:0]    paddr,
  input  logic [((PHASE_FRAC_BITS >= 32) ? 64 : 32)-1:0]  pwdata,
  output logic [((PHASE_FRAC_BITS >= 32) ? 64 : 32)-1:0]  prdata,
  output logic                                            pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     restart_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output sto_pkg::sample_t         sample_o
);

  import sto_pkg::*;

  localparam int unsigned PW      = PHASE_FRAC_BITS + 1;
  localparam int unsigned AddrLsb = (PHASE_FRAC_BITS >= 32) ? 3 : 2;
  localparam int unsigned AW      = AddrLsb + REG_IDX_W;
  localparam int unsigned DW      = (PHASE_FRAC_BITS >= 32) ? 64 : 32;

  logic [PW-1:0] rise_inc_q, fall_inc_q, start_phase_q;
  sample_t       out_max_q, out_min_q;
  logic          start_rising_q;
  reg_idx_e      reg_idx;
  logic          wr_en;

  logic          en;
  logic          accept;
  logic          v1_q, v2_q, v3_q;
  logic [PW-1:0] phase;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AW-1:AddrLsb]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_inc_q     <= '0;
      fall_inc_q     <= '0;
      out_max_q      <= '0;
      out_min_q      <= '0;
      start_phase_q  <= '0;
      start_rising_q <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RISE_INC:     rise_inc_q     <= pwdata[PW-1:0];
        REG_FALL_INC:     fall_inc_q     <= pwdata[PW-1:0];
        REG_OUT_MAX:      out_max_q      <= pwdata[SAMPLE_W-1:0];
        REG_OUT_MIN:      out_min_q      <= pwdata[SAMPLE_W-1:0];
        REG_START_PHASE:  start_phase_q  <= pwdata[PW-1:0];
        REG_START_RISING: start_rising_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RISE_INC:     prdata = DW'(rise_inc_q);
      REG_FALL_INC:     prdata = DW'(fall_inc_q);
      REG_OUT_MAX:      prdata = DW'(out_max_q);
      REG_OUT_MIN:      prdata = DW'(out_min_q);
      REG_START_PHASE:  prdata = DW'(start_phase_q);
      REG_START_RISING: prdata = DW'(start_rising_q);
      default:          prdata = '0;
    endcase
  end

  // Pipe control: all stages advance together unless the output beat stalls
  assign en         = !v3_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  sto_phase #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_phase (
    .clk_i,
    .rst_ni,
    .step_i         (accept),
    .restart_i,
    .rise_inc_i     (rise_inc_q),
    .fall_inc_i     (fall_inc_q),
    .start_phase_i  (start_phase_q),
    .start_rising_i (start_rising_q),
    .phase_o        (phase)
  );

  sto_scale #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_scale (
    .clk_i,
    .en_i      (en),
    .phase_i   (phase),
    .out_max_i (out_max_q),
    .out_min_i (out_min_q),
    .sample_o
  );

  assign out_valid_o = v3_q;

  `STO_ASSERT(a_stall_freezes, !en |=> $stable(v1_q) && $stable(v2_q))
  `STO_ASSERT(a_no_accept_stalled, (v3_q && !out_ready_i) |-> !accept)
  `STO_ASSERT(a_pipe_moves, (en && v2_q) |=> v3_q)

endmodule

[rtl/sto_phase.sv]
// ----------------------------------------------------------------------------
// Phase accumulator
// Steps the phase up or down per beat, clamps at 0 and 1.0, turns direction.
// ----------------------------------------------------------------------------
`include "skewed_triangle_oscillator_top_defines.svh"

module sto_phase #(
  parameter int unsigned PHASE_FRAC_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     restart_i,
  input  logic [PHASE_FRAC_BITS:0] rise_inc_i,
  input  logic [PHASE_FRAC_BITS:0] fall_inc_i,
  input  logic [PHASE_FRAC_BITS:0] start_phase_i,
  input  logic                     start_rising_i,
  output logic [PHASE_FRAC_BITS:0] phase_o
);

  localparam int unsigned PW = PHASE_FRAC_BITS + 1;
  localparam logic [PW-1:0] PhaseOne = {1'b1, {PHASE_FRAC_BITS{1'b0}}};

  logic [PW-1:0] phase_q, phase_d;
  logic          rising_q, rising_d;
  logic [PW-1:0] base;
  logic          dir;
  logic [PW:0]   sum;
  logic [PW-1:0] stepped;
  logic          clamp_hi;

  always_comb begin
    base     = restart_i ? start_phase_i  : phase_q;
    dir      = restart_i ? start_rising_i : rising_q;
    sum      = {1'b0, base} + {1'b0, rise_inc_i};
    clamp_hi = 1'b0;
    stepped  = '0;
    if (dir) begin
      clamp_hi = (sum >= {1'b0, PhaseOne});
      stepped  = sum[PW-1:0];
    end else begin
      stepped  = (fall_inc_i >= base) ? '0 : base - fall_inc_i;
      clamp_hi = (stepped >= PhaseOne);
    end
    if (clamp_hi) begin
      phase_d  = PhaseOne;
      rising_d = 1'b0;
    end else if (stepped == '0) begin
      phase_d  = '0;
      rising_d = 1'b1;
    end else begin
      phase_d  = stepped;
      rising_d = dir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      rising_q <= 1'b1;
    end else if (step_i) begin
      phase_q  <= phase_d;
      rising_q <= rising_d;
    end
  end

  assign phase_o = phase_q;

  `STO_ASSERT(a_phase_bounded, step_i |=> (phase_q <= PhaseOne))
  `STO_ASSERT(a_top_falls, step_i |=> (phase_q != PhaseOne || !rising_q))
  `STO_ASSERT(a_floor_rises, step_i |=> (phase_q != '0 || rising_q))
  `STO_ASSERT(a_phase_holds, !step_i |=> $stable(phase_q) && $stable(rising_q))

endmodule

[rtl/sto_scale.sv]
// ----------------------------------------------------------------------------
// Sample scaler
// Maps the phase onto out_min..out_max, truncating toward zero. Two stages.
// ----------------------------------------------------------------------------
module sto_scale #(
  parameter int unsigned PHASE_FRAC_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [PHASE_FRAC_BITS:0] phase_i,
  input  sto_pkg::sample_t         out_max_i,
  input  sto_pkg::sample_t         out_min_i,
  output sto_pkg::sample_t         sample_o
);

  import sto_pkg::*;

  localparam int unsigned F  = PHASE_FRAC_BITS;
  localparam int unsigned PW = F + 1;
  localparam int unsigned NW = PW + SAMPLE_W + 2;
  localparam int unsigned XW = NW - SAMPLE_W - F;

  logic signed [PW:0]         phase_s;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [NW-1:0]       prod_d, prod_q;
  logic signed [NW-1:0]       min_ext;
  logic signed [NW-1:0]       num;
  logic signed [NW-1:0]       adj;
  sample_t                    sample_d, sample_q;

  assign phase_s = {1'b0, phase_i};
  assign diff    = {out_max_i[SAMPLE_W-1], out_max_i} - {out_min_i[SAMPLE_W-1], out_min_i};
  assign prod_d  = phase_s * diff;

  // toward-zero truncation: bias negative values by one LSB short of 1.0
  assign min_ext  = {{XW{out_min_i[SAMPLE_W-1]}}, out_min_i, {F{1'b0}}};
  assign num      = min_ext + prod_q;
  assign adj      = num + (num[NW-1] ? {{(NW-F){1'b0}}, {F{1'b1}}} : '0);
  assign sample_d = adj[F+SAMPLE_W-1:F];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule
